/* src/sfd_pkg.sv */
package sfd_pkg;

   // slip framing codes
   localparam logic [7:0] CODE_END     = 8'hC0;
   localparam logic [7:0] CODE_ESC     = 8'hDB;
   localparam logic [7:0] CODE_ESC_END = 8'hDC;
   localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

   // crc-16/x-25, reflected
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_GOOD  = 16'hF0B8;
   localparam logic [15:0] CRC_RESET = 16'hFFFF;

   // header plus fcs
   localparam int MIN_FRAME_BYTES = 4;

   localparam int IDX_W = 9;

   // classified byte from the front end
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } token_type;

   // one result item
   typedef struct packed {
      logic             kind;
      logic [7:0]       data_byte;
      logic [IDX_W-1:0] byte_index;
      logic [IDX_W-1:0] payload_length;
      logic             crc_ok;
      logic             overflow;
   } result_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] c;
      c = crc_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* src/sfd_front.sv */
module sfd_front
   import sfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  logic [7:0] in_byte,
   input  logic      q_ready,
   output logic      in_ready,
   output logic      push,
   output token_type push_token
);

   logic escape_pending_ff, escape_pending_in;
   logic accept;

   assign in_ready = q_ready;
   assign accept   = in_valid && q_ready;

   always_comb begin
      escape_pending_in = escape_pending_ff;
      push              = 1'b0;
      push_token.is_end = 1'b0;
      push_token.data   = in_byte;
      if (accept) begin
         priority if (in_byte == CODE_END) begin
            // frame close always goes to the back end, pending escape dropped
            push              = 1'b1;
            push_token.is_end = 1'b1;
            escape_pending_in = 1'b0;
         end else if (in_byte == CODE_ESC) begin
            escape_pending_in = 1'b1;
         end else begin
            push = 1'b1;
            if (escape_pending_ff) begin
               if (in_byte == CODE_ESC_END) begin
                  push_token.data = CODE_END;
               end else if (in_byte == CODE_ESC_ESC) begin
                  push_token.data = CODE_ESC;
               end
            end
            escape_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
      end else begin
         escape_pending_ff <= escape_pending_in;
      end
   end

endmodule

/* src/sfd_queue.sv */
module sfd_queue
   import sfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      push_ready,
   input  logic      pop,
   output logic      pop_valid,
   output token_type pop_token
);

   token_type  slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_token  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

/* src/sfd_back.sv */
module sfd_back
   import sfd_pkg::*;
#(
   parameter int MAX_FRAME = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        q_valid,
   input  token_type   q_token,
   output logic        q_pop,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_result
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int EXT_W = CNT_W + IDX_W;
   localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_FRAME);
   localparam logic [EXT_W-1:0] MIN_EXT = EXT_W'(MIN_FRAME_BYTES);

   logic [15:0]      seed_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic             ovf_ff, ovf_in;
   logic             valid_ff, valid_in;
   result_type       result_ff, result_in;

   logic [EXT_W-1:0] cnt_ext, len_ext;
   logic             can_load;

   assign cnt_ext  = {{IDX_W{1'b0}}, count_ff};
   assign len_ext  = cnt_ext - MIN_EXT;
   assign can_load = !valid_ff || out_ready;
   assign q_pop    = q_valid && can_load;

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      count_in  = count_ff;
      crc_in    = crc_ff;
      ovf_in    = ovf_ff;
      valid_in  = valid_ff && !out_ready;
      result_in = result_ff;
      if (q_pop) begin
         if (q_token.is_end) begin
            if (cnt_ext >= MIN_EXT) begin
               valid_in                 = 1'b1;
               result_in.kind           = 1'b1;
               result_in.data_byte      = 8'h00;
               result_in.byte_index     = '0;
               result_in.payload_length = len_ext[IDX_W-1:0];
               result_in.crc_ok         = (crc_ff == CRC_GOOD) && !ovf_ff;
               result_in.overflow       = ovf_ff;
            end
            count_in = '0;
            crc_in   = seed_ff;
            ovf_in   = 1'b0;
         end else if (cnt_ext >= MAX_EXT) begin
            ovf_in = 1'b1;
         end else begin
            crc_in = crc_feed((count_ff == '0) ? seed_ff : crc_ff, q_token.data);
            valid_in                 = 1'b1;
            result_in.kind           = 1'b0;
            result_in.data_byte      = q_token.data;
            result_in.byte_index     = cnt_ext[IDX_W-1:0];
            result_in.payload_length = '0;
            result_in.crc_ok         = 1'b0;
            result_in.overflow       = 1'b0;
            count_in                 = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= CRC_RESET;
         count_ff <= '0;
         crc_ff   <= CRC_RESET;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            seed_ff <= csr_wdata;
         end
         count_ff <= count_in;
         crc_ff   <= crc_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* src/slip_frame_decoder_crc16_top.sv */
// a byte taken first sits in the queue, is then loaded into the result register
// and leaves from there as a result transaction
// throughput: one byte per cycle sustained; the back end drains one queued byte per cycle
// a stalled result port fills the two-entry queue, then req_tready falls
// reset: synchronous, active high; clears escape, count, overflow, queue and result valid,
// and loads the crc seed register with 0xffff
module slip_frame_decoder_crc16_top
   import sfd_pkg::*;
#(
   parameter int MAX_FRAME = 512
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: crc seed
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   // received serial bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // decoded results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [16:8] byte_index,
                                    // [25:17] payload_length, [26] crc_ok,
                                    // [27] overflow, [31:28] zero
   output logic        rsp_tuser    // [0] result_kind: 0 data byte, 1 frame end
);

   logic       front_push;
   token_type  front_token;
   logic       q_ready;
   logic       q_valid;
   token_type  q_token;
   logic       q_pop;
   result_type result;

   // front end: unescapes and classifies each transaction
   sfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .q_ready    (q_ready),
      .in_ready   (req_tready),
      .push       (front_push),
      .push_token (front_token)
   );

   // short queue so each side can stall on its own
   sfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_token (front_token),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_token  (q_token)
   );

   // back end: frame counting, crc and the result register
   sfd_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_token    (q_token),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // pack result fields, highest first
   assign rsp_tdata = {4'h0, result.overflow, result.crc_ok, result.payload_length,
                       result.byte_index, result.data_byte};
   assign rsp_tuser = result.kind;

endmodule

/* tb/tb_slip_frame_decoder_crc16_top.sv */
module tb_slip_frame_decoder_crc16_top;
   import sfd_pkg::*;

   localparam int FRAME_LIMIT = 512;
   // cycles with no transaction on either side before the run is abandoned
   localparam int QUIET_LIMIT = 3000;
   // receiver hold-off long enough to fill the block and stall its input
   localparam int LONG_HOLD = 80;
   localparam int PRINT_LIMIT = 40;

   // result_kind codes carried on rsp_tuser
   localparam logic KIND_DATA      = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [7:0] data_byte, [16:8] byte_index,
                                     // [25:17] payload_length, [26] crc_ok, [27] overflow
   logic        rsp_tuser;           // [0] result_kind

   // serial bytes waiting to be offered, and decoded results still owed by the block
   logic [7:0]  serial_bytes[$];
   result_type  decoded_queue[$];

   // decoder state as the block should hold it
   logic        esc_armed = 1'b0;
   int          kept_bytes = 0;
   logic [15:0] crc_acc = CRC_RESET;
   logic        bytes_dropped = 1'b0;
   logic [15:0] active_seed = CRC_RESET;

   int          send_idle_pct = 16;
   int          recv_idle_pct = 85;
   int          bytes_queued = 0;
   int          bytes_taken = 0;
   int          results_seen = 0;
   int          data_results = 0;
   int          frames_closed = 0;
   int          good_frames = 0;
   int          overflowed_frames = 0;
   int          failures = 0;
   int          hold_left = 0;
   int          next_hold_at = 150;
   int          quiet_cycles = 0;
   logic [15:0] random_seed = '0;

   always #4 clock = ~clock;

   slip_frame_decoder_crc16_top #(
      .MAX_FRAME(FRAME_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // reflected crc-16, one byte at a time, lsb first
   function automatic logic [15:0] x25_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
      return c;
   endfunction

   // works out what one accepted serial byte should produce
   function automatic void decode_serial_byte(input logic [7:0] raw);
      result_type r;
      logic [7:0] b;
      r = '0;
      b = raw;
      if (raw == CODE_END) begin
         // frame close: only frames holding header and fcs report
         if (kept_bytes >= MIN_FRAME_BYTES) begin
            r.kind = KIND_FRAME_END;
            r.payload_length = IDX_W'(kept_bytes - MIN_FRAME_BYTES);
            r.crc_ok = (crc_acc == CRC_GOOD) && !bytes_dropped;
            r.overflow = bytes_dropped;
            decoded_queue.push_back(r);
         end
         esc_armed = 1'b0;
         kept_bytes = 0;
         crc_acc = active_seed;
         bytes_dropped = 1'b0;
      end else if (raw == CODE_ESC) begin
         // a second escape simply keeps it armed
         esc_armed = 1'b1;
      end else begin
         if (esc_armed) begin
            if (raw == CODE_ESC_END) begin
               b = CODE_END;
            end else if (raw == CODE_ESC_ESC) begin
               b = CODE_ESC;
            end
            esc_armed = 1'b0;
         end
         if (kept_bytes >= FRAME_LIMIT) begin
            bytes_dropped = 1'b1;
         end else begin
            // seed picked up at the first byte, so a mid-frame write waits for the next frame
            if (kept_bytes == 0) begin
               crc_acc = active_seed;
            end
            crc_acc = x25_update(crc_acc, b);
            r.kind = KIND_DATA;
            r.data_byte = b;
            r.byte_index = kept_bytes[IDX_W-1:0];
            kept_bytes++;
            decoded_queue.push_back(r);
         end
      end
   endfunction

   function automatic void feed(input logic [7:0] b);
      serial_bytes.push_back(b);
      bytes_queued++;
   endfunction

   // slip stuffing of one frame byte
   function automatic void feed_escaped(input logic [7:0] b);
      if (b == CODE_END) begin
         feed(CODE_ESC);
         feed(CODE_ESC_END);
      end else if (b == CODE_ESC) begin
         feed(CODE_ESC);
         feed(CODE_ESC_ESC);
      end else begin
         feed(b);
      end
   endfunction

   // frame content, with framing codes common enough that stuffing is exercised
   function automatic logic [7:0] frame_byte();
      if ($urandom_range(7, 0) == 0) begin
         return $urandom_range(1, 0) ? CODE_END : CODE_ESC;
      end
      return 8'($urandom_range(255, 0));
   endfunction

   // line noise: bare codes, stray escapes and anything else
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(4, 0))
         0: return CODE_END;
         1: return CODE_ESC;
         2: return CODE_ESC_END;
         3: return CODE_ESC_ESC;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   // body plus fcs (complement of the crc, low byte first), stuffed and closed by END
   function automatic void queue_frame(input int body_len, input bit fcs_good,
                                       input logic [15:0] seed, input bit lead_end);
      logic [15:0] acc;
      logic [15:0] fcs;
      logic [7:0]  b;
      acc = seed;
      if (lead_end) begin
         feed(CODE_END);
      end
      for (int i = 0; i < body_len; i++) begin
         b = frame_byte();
         acc = x25_update(acc, b);
         feed_escaped(b);
      end
      fcs = ~acc;
      if (!fcs_good) begin
         fcs ^= 16'h0001 << $urandom_range(15, 0);
      end
      feed_escaped(fcs[7:0]);
      feed_escaped(fcs[15:8]);
      feed(CODE_END);
   endfunction

   // mostly well-formed frames of random content, the rest noise bursts
   function automatic void queue_traffic(input int n_bytes, input logic [15:0] seed);
      int target;
      int body_len;
      target = bytes_queued + n_bytes;
      while (bytes_queued < target) begin
         if ($urandom_range(99, 0) < 78) begin
            body_len = ($urandom_range(6, 0) == 0) ? $urandom_range(60, 25)
                                                   : $urandom_range(24, 0);
            queue_frame(body_len, $urandom_range(3, 0) != 0, seed, $urandom_range(4, 0) < 3);
         end else begin
            repeat ($urandom_range(6, 1)) feed(noise_byte());
         end
      end
   endfunction

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         if (failures < PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
         end
         failures++;
      end
   endfunction

   // sender: one byte per transaction, idling at random between bytes
   always @(posedge clock) begin : req_side
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_serial_byte(req_tdata);
            bytes_taken++;
         end
         // a byte on offer stays until taken
         if (!req_tvalid || req_tready) begin
            if (serial_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_tdata <= serial_bytes.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result transaction against the oldest prediction
   always @(posedge clock) begin : rsp_side
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_queue.size() == 0) begin
               if (failures < PRINT_LIMIT) begin
                  $display("%0t: result with none expected, actual kind %0d tdata 0x%08h",
                           $time, rsp_tuser, rsp_tdata);
               end
               failures++;
            end else begin
               want = decoded_queue.pop_front();
               check_field("result_kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_tdata[7:0]));
               check_field("byte_index", 32'(want.byte_index), 32'(rsp_tdata[16:8]));
               check_field("payload_length", 32'(want.payload_length),
                           32'(rsp_tdata[25:17]));
               check_field("crc_ok", 32'(want.crc_ok), 32'(rsp_tdata[26]));
               check_field("overflow", 32'(want.overflow), 32'(rsp_tdata[27]));
               if (want.kind == KIND_FRAME_END) begin
                  frames_closed++;
                  good_frames += 32'(want.crc_ok);
                  overflowed_frames += 32'(want.overflow);
               end else begin
                  data_results++;
               end
            end
            results_seen++;
         end
         // now and then a long hold-off while the sender keeps offering
         if (hold_left == 0 && results_seen >= next_hold_at) begin
            hold_left = LONG_HOLD;
            next_hold_at += 1000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("** slip_frame_decoder_crc16_top: FAILED **");
         $finish;
      end
   end

   // everything offered, taken and answered, then a few cycles for bytes still in flight
   task automatic wait_idle();
      while (serial_bytes.size() != 0 || req_tvalid || decoded_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_seed(input logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      active_seed = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: lone END, escape cleared by a short frame, double escape,
      // escaped byte passed raw, bare DC/DD, extreme data bytes, minimum frames
      feed(CODE_END);
      feed(8'h11);
      feed(CODE_ESC);
      feed(CODE_END);
      feed(CODE_ESC_END);
      feed(CODE_ESC_ESC);
      feed(CODE_ESC);
      feed(CODE_ESC);
      feed(CODE_ESC_END);
      feed(CODE_ESC);
      feed(8'h41);
      feed(8'hFF);
      feed(8'h00);
      feed(CODE_END);
      queue_frame(2, 1'b1, CRC_RESET, 1'b0);
      queue_frame(3, 1'b0, CRC_RESET, 1'b0);
      wait_idle();

      // zero seed, sender mostly busy, receiver mostly stalled
      write_seed(16'h0000);
      queue_traffic(300, 16'h0000);
      // leave a frame open across the next seed write
      feed(8'h5A);
      feed(8'h13);
      feed(8'hA7);
      wait_idle();

      // all-ones seed, sender mostly idle; includes a full-length good frame
      send_idle_pct = 85;
      recv_idle_pct = 16;
      write_seed(CRC_RESET);
      feed(8'h3C);
      feed(8'h01);
      feed(8'h99);
      feed(CODE_END);
      queue_frame(FRAME_LIMIT - 2, 1'b1, CRC_RESET, 1'b1);
      queue_traffic(60, CRC_RESET);
      wait_idle();

      // random seed, no random idling on either side; includes an overlong frame
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_seed = 16'($urandom_range(16'hFFFF, 0));
      write_seed(random_seed);
      queue_frame(FRAME_LIMIT + 1, 1'b1, random_seed, 1'b1);
      queue_traffic(120, random_seed);
      wait_idle();
      repeat (8) @(posedge clock);

      $display("covered %0d serial bytes, %0d decoded bytes, %0d frame ends",
               bytes_taken, data_results, frames_closed);
      $display("(%0d good, %0d overflowed), crc seeds 0xffff, 0x0000 and 0x%04h",
               good_frames, overflowed_frames, random_seed);
      if (failures == 0) begin
         $display("** slip_frame_decoder_crc16_top: PASSED **");
      end else begin
         $display("** slip_frame_decoder_crc16_top: FAILED **");
      end
      $finish;
   end

endmodule
